>>> hw/rtl/hilbert_band_envelope_analyzer_defines.svh
// Assertion helpers; the using module provides clk and rst.
`ifndef HILBERT_BAND_ENVELOPE_ANALYZER_DEFINES_SVH
`define HILBERT_BAND_ENVELOPE_ANALYZER_DEFINES_SVH

// Same-cycle implication.
`define HBEA_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define HBEA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/hbea_pkg.sv
package hbea_pkg;

  localparam int ROM_BANDS    = 32;
  localparam int HILB_LEN     = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 27;

  typedef logic signed [23:0] coef_t;

  localparam logic [0:0] REG_ATTACK  = 1'b0;
  localparam logic [0:0] REG_RELEASE = 1'b1;

  typedef struct packed {
    logic signed [23:0] y1;
    logic signed [23:0] y2;
    logic        [23:0] env;
    logic        [15:0] last_phase;
    logic signed [31:0] phase_sum;
  } band_state_t;

  localparam coef_t ROM_B0 [ROM_BANDS] = '{
    0: 24'sd11115, 1: 24'sd21405, 2: 24'sd41122, 3: 24'sd78612,
    4: 24'sd148735, 5: 24'sd275031, 6: 24'sd481753, 7: 24'sd733065,
    default: 24'sd0
  };

  localparam coef_t ROM_A1 [ROM_BANDS] = '{
    0: -24'sd8365835, 1: -24'sd8343778, 2: -24'sd8298868, 3: -24'sd8203705,
    4: -24'sd7989877, 5: -24'sd7474948, 6: -24'sd6168332, 7: -24'sd2892006,
    default: 24'sd0
  };

  localparam coef_t ROM_GAIN [ROM_BANDS] = '{
    0: 24'sd4194304, 1: 24'sd4194304, 2: 24'sd4194304, 3: 24'sd4194304,
    4: 24'sd6290189, 5: 24'sd4389982, 6: 24'sd4198297, 7: 24'sd4193416,
    default: 24'sd0
  };

  localparam coef_t ROM_HILB [HILB_LEN] = '{
    0: -24'sd2648, 2: -24'sd14830, 4: -24'sd43699, 6: -24'sd100582,
    8: -24'sd203454, 10: -24'sd390858, 12: -24'sd796959, 14: -24'sd2637859,
    16: 24'sd2637859, 18: 24'sd796959, 20: 24'sd390858, 22: 24'sd203454,
    24: 24'sd100582, 26: 24'sd43699, 28: 24'sd14830, 30: 24'sd2648,
    default: 24'sd0
  };

  localparam logic [15:0] ROM_ATAN [CORDIC_STEPS] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
  };

endpackage

>>> hw/rtl/hbea_cordic.sv
module hbea_cordic
  import hbea_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [23:0]         re,
  input  logic signed [23:0]         im,
  output logic                       done,
  output logic        [CORDIC_W-1:0] mag_x,
  output logic        [15:0]         ang
);

  localparam int KW = $clog2(CORDIC_STEPS);

  logic                       busy;
  logic        [KW-1:0]       k;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic        [15:0]         a;
  logic                       zero;

  assign dx = x >>> k;
  assign dy = y >>> k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
        zero <= (re == 24'sd0) && (im == 24'sd0);
        if (re[23]) begin
          x <= -CORDIC_W'(re);
          y <= -CORDIC_W'(im);
          a <= 16'h8000;
        end else begin
          x <= CORDIC_W'(re);
          y <= CORDIC_W'(im);
          a <= 16'h0000;
        end
      end else if (busy) begin
        if (y[CORDIC_W-1]) begin
          x <= x - dy;
          y <= y + dx;
          a <= a - ROM_ATAN[k];
        end else begin
          x <= x + dy;
          y <= y - dx;
          a <= a + ROM_ATAN[k];
        end
        k <= k + 1'b1;
        if (k == KW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign mag_x = x[CORDIC_W-1] ? '0 : x;
  assign ang   = zero ? 16'h0000 : a;

endmodule

>>> hw/rtl/hilbert_band_envelope_analyzer.sv
// Channel  Transfer when                    Payload
// sample   sample_valid & sample_ready      sample, block_end
// result   result_valid & result_ready      band, envelope, phase, frequency, last
// config   wr_en (no handshake)             wr_index, wr_data
// Per sample each band is processed in turn; the tap sweep over the single ring
// memory read port and the 16-step CORDIC take most of the time.
// On a block end each band also runs the 33-step frequency divider.
// After reset a clearing pass zeroes both memories; no sample is taken meanwhile.
// A stalled result only holds the band loop at its result step.
module hilbert_band_envelope_analyzer
  import hbea_pkg::*;
#(
  parameter int BANDS       = 8,
  parameter int TAPS        = 31,
  parameter int GROUP_DELAY = 15,
  parameter int SAMPLE_RATE = 44100,
  parameter int MAX_BLOCK   = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [15:0] sample,
  input  logic               block_end,
  output logic               result_valid,
  input  logic               result_ready,
  output logic        [2:0]  band,
  output logic        [15:0] envelope,
  output logic signed [15:0] phase,
  output logic signed [15:0] frequency,
  output logic               last,
  input  logic               wr_en,
  input  logic        [0:0]  wr_index,
  input  logic        [15:0] wr_data
);

`include "hilbert_band_envelope_analyzer_defines.svh"

  localparam int BW     = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int TW     = $clog2(TAPS);
  localparam int RD     = BANDS * TAPS;
  localparam int RAW    = $clog2(RD);
  localparam int CW     = $clog2(MAX_BLOCK + 1);
  localparam int GD_IDX = GROUP_DELAY % TAPS;
  localparam int DIV_W  = 33;
  localparam int DKW    = $clog2(DIV_W);
  localparam logic signed [24:0] SR_Q = 25'(SAMPLE_RATE);

  typedef enum logic [23:0] {
    S_CLEAR  = 24'd1 << 0,
    S_IDLE   = 24'd1 << 1,
    S_BREAD  = 24'd1 << 2,
    S_B0     = 24'd1 << 3,
    S_A1     = 24'd1 << 4,
    S_A2     = 24'd1 << 5,
    S_Y      = 24'd1 << 6,
    S_FIR    = 24'd1 << 7,
    S_FDRAIN = 24'd1 << 8,
    S_HR     = 24'd1 << 9,
    S_SC1    = 24'd1 << 10,
    S_SC2    = 24'd1 << 11,
    S_CINIT  = 24'd1 << 12,
    S_COR    = 24'd1 << 13,
    S_MAG    = 24'd1 << 14,
    S_MAG2   = 24'd1 << 15,
    S_ENV1   = 24'd1 << 16,
    S_ENV2   = 24'd1 << 17,
    S_ENV3   = 24'd1 << 18,
    S_FMUL   = 24'd1 << 19,
    S_FNUM   = 24'd1 << 20,
    S_FDIV0  = 24'd1 << 21,
    S_FDIV   = 24'd1 << 22,
    S_OUT    = 24'd1 << 23
  } state_t;

  function automatic logic signed [57:0] rnd22(input logic signed [57:0] v);
    return (v + 58'sd2097152) >>> 22;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [57:0] v);
    if (v > 58'sd8388607) return 24'sh7FFFFF;
    if (v < -58'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  state_t state;

  logic        [15:0]   attack_coef;
  logic        [15:0]   release_coef;
  logic signed [23:0]   x0, x1, x2;
  logic                 end_flag;
  logic        [CW-1:0] cnt;
  logic        [CW-1:0] count;
  logic        [TW-1:0] pos;
  logic        [BW-1:0] bidx;
  logic        [RAW-1:0] base;
  logic        [TW-1:0] tap, ptr, tap_d;
  logic                 v1, v2;
  logic signed [57:0]   acc, hs, eacc, prod;
  logic signed [23:0]   y0, re_raw, re, im;
  logic signed [32:0]   hsr;
  logic        [23:0]   mag, e_hold;
  logic        [16:0]   acoef;
  logic signed [31:0]   sum_new;
  logic        [49:0]   magn;
  logic                 neg;
  logic        [DIV_W-1:0] quo;
  logic        [CW-1:0] rem;
  logic        [DKW-1:0] dk;
  logic        [RAW-1:0] clr;

  logic signed [23:0]   ring_mem [RD];
  logic signed [23:0]   ring_q;
  band_state_t          band_mem [BANDS];
  band_state_t          bq;

  logic                 ring_we, ring_re, band_we;
  logic        [RAW-1:0] ring_wa, ring_ra;
  logic signed [23:0]   ring_wd;
  logic        [BW-1:0] band_wa;
  band_state_t          band_wd;

  logic signed [32:0]   ma;
  logic signed [24:0]   mb;
  logic signed [23:0]   b0_c, a1_c, g_c, tap_data;
  logic signed [24:0]   a2_c;
  logic signed [57:0]   acc_y;
  logic signed [23:0]   y_sat;
  logic        [16:0]   acoef_sel;
  logic        [23:0]   e_calc;
  logic        [15:0]   d;
  logic signed [31:0]   sum_calc;
  logic        [49:0]   num_n;
  logic        [CW:0]   rem_sh;
  logic                 ge;
  logic        [CW-1:0] rem_n;
  logic signed [15:0]   freq_calc;
  logic                 last_band;
  logic                 advance;
  logic        [CW-1:0] cnt_calc;
  logic                 in_xfer;

  logic                 cordic_start, cordic_done;
  logic [CORDIC_W-1:0]  cx;
  logic [15:0]          ang;

  hbea_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .re    (re),
    .im    (im),
    .done  (cordic_done),
    .mag_x (cx),
    .ang   (ang)
  );

  assign cordic_start = (state == S_CINIT);
  assign sample_ready = (state == S_IDLE);
  assign in_xfer      = sample_valid && sample_ready;
  assign last_band    = (bidx == BW'(BANDS - 1));
  assign cnt_calc     = count + 1'b1;

  assign b0_c = ROM_B0[5'(bidx)];
  assign a1_c = ROM_A1[5'(bidx)];
  assign g_c  = ROM_GAIN[5'(bidx)];
  assign a2_c = 25'sd4194304 - {b0_c, 1'b0};

  assign tap_data  = (tap_d == '0) ? y0 : ring_q;
  assign acc_y     = acc - prod;
  assign y_sat     = sat24(rnd22(acc_y));
  assign acoef_sel = (mag > bq.env) ? {1'b0, attack_coef} : {1'b0, release_coef};
  assign e_calc    = 24'((eacc + prod + 58'sd32768) >>> 16);
  assign d         = ang - bq.last_phase;
  assign sum_calc  = bq.phase_sum + {{16{d[15]}}, d};
  assign num_n     = magn + (50'(cnt) << 15);
  assign rem_sh    = {rem, quo[DIV_W-1]};
  assign ge        = (rem_sh >= {1'b0, cnt});
  assign rem_n     = ge ? CW'(rem_sh - {1'b0, cnt}) : rem_sh[CW-1:0];

  always_comb begin
    if (neg) begin
      freq_calc = (quo >= 33'd32768) ? 16'sh8000 : -$signed(quo[15:0]);
    end else begin
      freq_calc = (quo > 33'd32767) ? 16'sh7FFF : $signed(quo[15:0]);
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_B0: begin
        ma = 33'($signed({x0[23], x0}) - $signed({x2[23], x2}));
        mb = 25'(b0_c);
      end
      S_A1: begin
        ma = 33'(bq.y1);
        mb = 25'(a1_c);
      end
      S_A2: begin
        ma = 33'(bq.y2);
        mb = a2_c;
      end
      S_FIR, S_FDRAIN: begin
        if (v1) begin
          ma = 33'(tap_data);
          mb = 25'(ROM_HILB[6'(tap_d)]);
        end
      end
      S_HR: begin
        ma = 33'(re_raw);
        mb = 25'(g_c);
      end
      S_SC1: begin
        ma = hsr;
        mb = 25'(g_c);
      end
      S_MAG: begin
        ma = $signed({6'b0, cx});
        mb = 25'sd39797;
      end
      S_ENV1: begin
        ma = $signed({9'b0, bq.env});
        mb = $signed({8'b0, acoef_sel});
      end
      S_ENV2: begin
        ma = $signed({9'b0, mag});
        mb = $signed({8'b0, 17'd65536 - acoef});
      end
      S_FMUL: begin
        ma = 33'(sum_new);
        mb = SR_Q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    ring_we = (state == S_CLEAR) || (state == S_Y);
    ring_wa = (state == S_CLEAR) ? clr : base + RAW'(pos);
    ring_wd = (state == S_CLEAR) ? 24'sd0 : y_sat;
    ring_re = (state == S_FIR);
    ring_ra = base + RAW'(ptr);
    band_we = ((state == S_CLEAR) && (clr < RAW'(BANDS))) || (state == S_ENV3);
    band_wa = (state == S_CLEAR) ? clr[BW-1:0] : bidx;
    if (state == S_CLEAR) begin
      band_wd = '0;
    end else begin
      band_wd.y1         = y0;
      band_wd.y2         = bq.y1;
      band_wd.env        = e_calc;
      band_wd.last_phase = ang;
      band_wd.phase_sum  = end_flag ? 32'sd0 : sum_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    if (ring_re) ring_q <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (band_we) band_mem[band_wa] <= band_wd;
    if (state == S_BREAD) bq <= band_mem[bidx];
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign advance = ((state == S_ENV3) && !end_flag) ||
                   ((state == S_OUT) && (!result_valid || result_ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      result_valid <= 1'b0;
      attack_coef  <= 16'd65486;
      release_coef <= 16'd65521;
      x1           <= '0;
      x2           <= '0;
      pos          <= '0;
      count        <= '0;
      bidx         <= '0;
      base         <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_ATTACK:  attack_coef  <= wr_data;
          REG_RELEASE: release_coef <= wr_data;
          default: ;
        endcase
      end

      if (result_valid && result_ready && (state != S_OUT)) result_valid <= 1'b0;

      v1 <= (state == S_FIR);
      v2 <= v1;
      if (v2) hs <= hs + prod;
      if (v1 && (tap_d == TW'(GD_IDX))) re_raw <= tap_data;

      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == RAW'(RD - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (sample_valid) begin
            x0       <= {{3{sample[15]}}, sample, 5'b0};
            cnt      <= cnt_calc;
            end_flag <= block_end || (cnt_calc >= CW'(MAX_BLOCK));
            bidx     <= '0;
            base     <= '0;
            state    <= S_BREAD;
          end
        end
        S_BREAD: state <= S_B0;
        S_B0:    state <= S_A1;
        S_A1: begin
          acc   <= prod;
          state <= S_A2;
        end
        S_A2: begin
          acc   <= acc - prod;
          state <= S_Y;
        end
        S_Y: begin
          y0    <= y_sat;
          hs    <= '0;
          tap   <= '0;
          ptr   <= pos;
          state <= S_FIR;
        end
        S_FIR: begin
          tap_d <= tap;
          tap   <= tap + 1'b1;
          ptr   <= (ptr == '0) ? TW'(TAPS - 1) : ptr - 1'b1;
          if (tap == TW'(TAPS - 1)) state <= S_FDRAIN;
        end
        S_FDRAIN: begin
          if (!v1 && !v2) state <= S_HR;
        end
        S_HR: begin
          hsr   <= 33'(rnd22(hs));
          state <= S_SC1;
        end
        S_SC1: begin
          re    <= sat24(rnd22(prod));
          state <= S_SC2;
        end
        S_SC2: begin
          im    <= sat24(rnd22(prod));
          state <= S_CINIT;
        end
        S_CINIT: state <= S_COR;
        S_COR: begin
          if (cordic_done) state <= S_MAG;
        end
        S_MAG: state <= S_MAG2;
        S_MAG2: begin
          if (((prod + 58'sd32768) >>> 16) > 58'sd16777215) begin
            mag <= 24'hFFFFFF;
          end else begin
            mag <= 24'((prod + 58'sd32768) >>> 16);
          end
          state <= S_ENV1;
        end
        S_ENV1: begin
          acoef <= acoef_sel;
          state <= S_ENV2;
        end
        S_ENV2: begin
          eacc  <= prod;
          state <= S_ENV3;
        end
        S_ENV3: begin
          sum_new <= sum_calc;
          e_hold  <= e_calc;
          if (end_flag) state <= S_FMUL;
        end
        S_FMUL: state <= S_FNUM;
        S_FNUM: begin
          neg   <= prod[57];
          magn  <= prod[57] ? 50'(-prod) : 50'(prod);
          state <= S_FDIV0;
        end
        S_FDIV0: begin
          quo   <= num_n[48:16];
          rem   <= '0;
          dk    <= '0;
          state <= S_FDIV;
        end
        S_FDIV: begin
          quo <= {quo[DIV_W-2:0], ge};
          rem <= rem_n;
          dk  <= dk + 1'b1;
          if (dk == DKW'(DIV_W - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            band         <= 3'(bidx);
            envelope     <= (e_hold[23:22] != 2'b00) ? 16'hFFFF : e_hold[21:6];
            phase        <= $signed(ang);
            frequency    <= freq_calc;
            last         <= last_band;
          end
        end
        default: state <= S_CLEAR;
      endcase

      if (advance) begin
        if (last_band) begin
          state <= S_IDLE;
          pos   <= (pos == TW'(TAPS - 1)) ? '0 : pos + 1'b1;
          count <= end_flag ? '0 : cnt;
          x2    <= x1;
          x1    <= x0;
        end else begin
          bidx  <= bidx + 1'b1;
          base  <= base + RAW'(TAPS);
          state <= S_BREAD;
        end
      end
    end
  end

  `HBEA_ASSERT_NEXT(a_accept_starts_band0, in_xfer, state == S_BREAD && bidx == '0, "no band 0")
  `HBEA_ASSERT_IMPLIES(a_result_only_at_end, state == S_OUT, end_flag, "result outside block end")
  `HBEA_ASSERT_IMPLIES(a_no_result_in_clear, state == S_CLEAR, !result_valid, "result while clearing")
  `HBEA_ASSERT_IMPLIES(a_cordic_done_waited, cordic_done, state == S_COR, "stray CORDIC done")

endmodule
